// File: hw/rtl/ffha_pkg.sv
// Package: types and constants for the first-fit heap allocator.
package ffha_pkg;
    localparam int unsigned HEADER_BYTES = 32;
    localparam int unsigned MAX_BLOCKS = 64;
    localparam int unsigned ADDR_BITS = 16;
    localparam int unsigned IDX_BITS = $clog2(MAX_BLOCKS);
    localparam int unsigned LINK_BITS = IDX_BITS + 1;
    localparam int unsigned TOP_BITS = ADDR_BITS + 1;
    localparam int unsigned LIMIT_BITS = 17;

    localparam logic [LINK_BITS-1:0] NONE_LINK = LINK_BITS'(MAX_BLOCKS);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] req_size;
        logic [15:0] data_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_address;
    } rsp_t;

    // one block table entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] blk_start;
        logic [15:0]          blk_bytes;
        logic [LINK_BITS-1:0] blk_next;
        logic [LINK_BITS-1:0] blk_prev;
    } blk_t;
endpackage

// File: hw/rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator with block split and coalesce.
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------
//  request | s_valid / s_ready / s_req      | ffha_pkg::req_t
//  result  | m_valid / m_ready / m_rsp      | ffha_pkg::rsp_t
//  config  | cfg_we / cfg_wdata             | heap_limit, 17 bits
//
// Sequence: one request at a time. An allocate walks the block list one entry
// per cycle; unless the block found is handed out whole, it then searches for
// a spare entry one per cycle and, if one is found, writes a split (S_SPLIT,
// S_SPLIT_N, S_SPLIT_B) or grows the heap top (S_GROW, S_GROW_L). A free scans
// the table for its address, then merges (S_MNEXT, S_MPREV, S_MFIX). Each
// request ends in S_RESP. The walks through the block table set the time.
// Reset: synchronous, active low; table empty, heap top zero, no clearing pass.
// Stalls: a result waits in its output register; s_ready stays low until
// the result is taken.
module first_fit_heap_allocator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ffha_pkg::req_t        s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ffha_pkg::rsp_t        m_rsp,
    input  logic                  cfg_we,
    input  logic [16:0]           cfg_wdata
);
    localparam int unsigned IB = ffha_pkg::IDX_BITS;
    localparam int unsigned LB = ffha_pkg::LINK_BITS;
    localparam int unsigned AB = ffha_pkg::ADDR_BITS;
    localparam int unsigned TB = ffha_pkg::TOP_BITS;
    localparam int unsigned NB = ffha_pkg::MAX_BLOCKS;
    localparam int unsigned HB = ffha_pkg::HEADER_BYTES;
    localparam logic [16:0] LIM_SPAN = 17'(1 << AB);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WALK    = 4'd1;   // first-fit list walk
    localparam logic [3:0] S_GRAB    = 4'd2;   // spare entry search
    localparam logic [3:0] S_SPLIT   = 4'd3;   // write remainder entry
    localparam logic [3:0] S_SPLIT_N = 4'd4;   // relink following block
    localparam logic [3:0] S_SPLIT_B = 4'd5;   // shrink the taken block
    localparam logic [3:0] S_GROW    = 4'd6;   // write new top block
    localparam logic [3:0] S_GROW_L  = 4'd7;   // link old last block to it
    localparam logic [3:0] S_FIND    = 4'd8;   // free: address search
    localparam logic [3:0] S_MNEXT   = 4'd9;
    localparam logic [3:0] S_MPREV   = 4'd10;
    localparam logic [3:0] S_MFIX    = 4'd11;  // prev link of following block
    localparam logic [3:0] S_RESP    = 4'd12;

    // Block table: one write and one registered read per cycle
    ffha_pkg::blk_t tbl_mem [NB];
    ffha_pkg::blk_t rd_reg;
    logic [IB-1:0]  rd_idx;
    logic           tw_en;
    logic [IB-1:0]  tw_idx;
    ffha_pkg::blk_t tw_data;

    logic [NB-1:0] free_reg, free_next;
    logic [NB-1:0] used_reg, used_next;

    logic [LB-1:0] first_reg, first_next;
    logic [LB-1:0] last_reg, last_next;
    logic [TB-1:0] top_reg, top_next;
    logic [16:0]   limit_reg;

    logic [3:0]    state_reg, state_next;
    ffha_pkg::req_t req_reg;
    logic [LB-1:0] cur_reg, cur_next;      // walk cursor / target block
    logic [LB-1:0] cnt_reg, cnt_next;      // step counter / spare entry
    logic          split_reg, split_next;  // grab is for a split
    ffha_pkg::blk_t ent_reg, ent_next;     // copy of the target entry
    ffha_pkg::rsp_t rsp_reg, rsp_next;
    logic          mval_reg, mval_next;

    logic [IB-1:0] ci, ki, nxi, pvi;
    logic [16:0]   sz_plus_hdr;
    logic [17:0]   grow_end;
    logic [16:0]   eff_limit;

    assign ci = cur_reg[IB-1:0];
    assign ki = cnt_reg[IB-1:0];
    assign nxi = ent_reg.blk_next[IB-1:0];
    assign pvi = ent_reg.blk_prev[IB-1:0];
    assign sz_plus_hdr = 17'(req_reg.req_size) + 17'(HB);
    assign grow_end = 18'(top_reg) + 18'(sz_plus_hdr);
    // growth never passes the address span
    assign eff_limit = (limit_reg > LIM_SPAN) ? LIM_SPAN : limit_reg;

    assign s_ready = (state_reg == S_IDLE) && !mval_reg;
    assign m_valid = mval_reg;
    assign m_rsp = rsp_reg;

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        split_next = split_reg;
        ent_next = ent_reg;
        rsp_next = rsp_reg;
        mval_next = mval_reg;
        free_next = free_reg;
        used_next = used_reg;
        first_next = first_reg;
        last_next = last_reg;
        top_next = top_reg;
        rd_idx = ci;
        tw_en = 1'b0;
        tw_idx = ci;
        tw_data = ent_reg;
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    rsp_next = '0;
                    cnt_next = '0;
                    cur_next = first_reg;
                    if (s_req.req_type == ffha_pkg::REQ_ALLOC) begin
                        if (s_req.req_size == 16'd0) begin
                            rsp_next.status = ffha_pkg::ST_ZERO_SIZE;
                            state_next = S_RESP;
                        end else begin
                            rd_idx = first_reg[IB-1:0];
                            state_next = S_WALK;
                        end
                    end else if (s_req.data_address == 16'd0) begin
                        state_next = S_RESP;
                    end else begin
                        rd_idx = '0;
                        state_next = S_FIND;
                    end
                end
            end
            S_WALK: begin
                // rd_reg holds the entry at cur_reg
                if (cur_reg == ffha_pkg::NONE_LINK || cnt_reg == LB'(NB)) begin
                    if (grow_end > 18'(eff_limit)) begin
                        rsp_next.status = ffha_pkg::ST_NO_SPACE;
                        state_next = S_RESP;
                    end else begin
                        split_next = 1'b0;
                        cnt_next = '0;
                        state_next = S_GRAB;
                    end
                end else if (free_reg[ci] && rd_reg.blk_bytes >= req_reg.req_size) begin
                    ent_next = rd_reg;
                    rsp_next.result_address = rd_reg.blk_start + AB'(HB);
                    if (17'(rd_reg.blk_bytes) > sz_plus_hdr) begin
                        split_next = 1'b1;
                        cnt_next = '0;
                        state_next = S_GRAB;
                    end else begin
                        free_next[ci] = 1'b0;
                        state_next = S_RESP;
                    end
                end else begin
                    cur_next = rd_reg.blk_next;
                    cnt_next = cnt_reg + 1'b1;
                    rd_idx = rd_reg.blk_next[IB-1:0];
                end
            end
            S_GRAB: begin
                if (cnt_reg == LB'(NB)) begin
                    // table full: a split hands the block out whole
                    if (split_reg) begin
                        free_next[ci] = 1'b0;
                    end else begin
                        rsp_next.status = ffha_pkg::ST_NO_SPACE;
                    end
                    state_next = S_RESP;
                end else if (!used_reg[ki]) begin
                    state_next = split_reg ? S_SPLIT : S_GROW;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SPLIT: begin
                tw_en = 1'b1;
                tw_idx = ki;
                tw_data.blk_start = ent_reg.blk_start + AB'(sz_plus_hdr);
                tw_data.blk_bytes = ent_reg.blk_bytes - 16'(sz_plus_hdr);
                tw_data.blk_next = ent_reg.blk_next;
                tw_data.blk_prev = cur_reg;
                used_next[ki] = 1'b1;
                free_next[ki] = 1'b1;
                free_next[ci] = 1'b0;
                if (last_reg == cur_reg) last_next = cnt_reg;
                rd_idx = nxi;
                state_next = S_SPLIT_N;
            end
            S_SPLIT_N: begin
                if (ent_reg.blk_next != ffha_pkg::NONE_LINK) begin
                    tw_en = 1'b1;
                    tw_idx = nxi;
                    tw_data = rd_reg;
                    tw_data.blk_prev = cnt_reg;
                end
                state_next = S_SPLIT_B;
            end
            S_SPLIT_B: begin
                tw_en = 1'b1;
                tw_idx = ci;
                tw_data = ent_reg;
                tw_data.blk_bytes = req_reg.req_size;
                tw_data.blk_next = cnt_reg;
                state_next = S_RESP;
            end
            S_GROW: begin
                tw_en = 1'b1;
                tw_idx = ki;
                tw_data.blk_start = top_reg[AB-1:0];
                tw_data.blk_bytes = req_reg.req_size;
                tw_data.blk_next = ffha_pkg::NONE_LINK;
                tw_data.blk_prev = last_reg;
                used_next[ki] = 1'b1;
                free_next[ki] = 1'b0;
                if (last_reg == ffha_pkg::NONE_LINK) begin
                    first_next = cnt_reg;
                end
                top_next = grow_end[TB-1:0];
                rsp_next.result_address = top_reg[AB-1:0] + AB'(HB);
                rd_idx = last_reg[IB-1:0];
                state_next = S_GROW_L;
            end
            S_GROW_L: begin
                if (last_reg != ffha_pkg::NONE_LINK) begin
                    tw_en = 1'b1;
                    tw_idx = last_reg[IB-1:0];
                    tw_data = rd_reg;
                    tw_data.blk_next = cnt_reg;
                end
                last_next = cnt_reg;
                state_next = S_RESP;
            end
            S_FIND: begin
                // rd_reg holds the entry at cnt_reg
                if (cnt_reg == LB'(NB)) begin
                    rsp_next.status = ffha_pkg::ST_BAD_FREE;
                    state_next = S_RESP;
                end else if (used_reg[ki] &&
                    (17'(rd_reg.blk_start) + 17'(HB)) == 17'(req_reg.data_address)) begin
                    free_next[ki] = 1'b1;
                    cur_next = cnt_reg;
                    ent_next = rd_reg;
                    rd_idx = rd_reg.blk_next[IB-1:0];
                    state_next = S_MNEXT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_idx = IB'(cnt_reg + 1'b1);
                end
            end
            S_MNEXT: begin
                // absorb next into cur; rd_reg holds next
                if (ent_reg.blk_next != ffha_pkg::NONE_LINK && free_reg[nxi]) begin
                    ent_next.blk_bytes = ent_reg.blk_bytes + rd_reg.blk_bytes + 16'(HB);
                    ent_next.blk_next = rd_reg.blk_next;
                    if (last_reg == ent_reg.blk_next) last_next = cur_reg;
                    used_next[nxi] = 1'b0;
                    free_next[nxi] = 1'b0;
                end
                rd_idx = pvi;
                state_next = S_MPREV;
            end
            S_MPREV: begin
                // absorb cur into prev; rd_reg holds prev
                if (ent_reg.blk_prev != ffha_pkg::NONE_LINK && free_reg[pvi]) begin
                    tw_en = 1'b1;
                    tw_idx = pvi;
                    tw_data = rd_reg;
                    tw_data.blk_bytes = rd_reg.blk_bytes + ent_reg.blk_bytes + 16'(HB);
                    tw_data.blk_next = ent_reg.blk_next;
                    if (last_reg == cur_reg) last_next = ent_reg.blk_prev;
                    used_next[ci] = 1'b0;
                    free_next[ci] = 1'b0;
                    cur_next = ent_reg.blk_prev;
                end else begin
                    tw_en = 1'b1;
                    tw_idx = ci;
                    tw_data = ent_reg;
                end
                rd_idx = nxi;
                state_next = S_MFIX;
            end
            S_MFIX: begin
                // following block points back at the surviving block
                if (ent_reg.blk_next != ffha_pkg::NONE_LINK) begin
                    tw_en = 1'b1;
                    tw_idx = nxi;
                    tw_data = rd_reg;
                    tw_data.blk_prev = cur_reg;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                mval_next = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg <= 1'b0;
            free_reg <= '0;
            used_reg <= '0;
            first_reg <= ffha_pkg::NONE_LINK;
            last_reg <= ffha_pkg::NONE_LINK;
            top_reg <= '0;
            limit_reg <= 17'h10000;
            cur_reg <= '0;
            cnt_reg <= '0;
            split_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg <= mval_next;
            free_reg <= free_next;
            used_reg <= used_next;
            first_reg <= first_next;
            last_reg <= last_next;
            top_reg <= top_next;
            cur_reg <= cur_next;
            cnt_reg <= cnt_next;
            split_reg <= split_next;
            if (cfg_we) limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
        ent_reg <= ent_next;
        if (s_valid && s_ready) req_reg <= s_req;
    end

    always_ff @(posedge aclk) begin
        rd_reg <= tbl_mem[rd_idx];
        if (tw_en) tbl_mem[tw_idx] <= tw_data;
    end

    // A free block is always a table entry in use.
    a_free_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg & ~used_reg) == '0) else $error("free entry not in use");
    // The heap top never moves down.
    a_top_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg >= $past(top_reg)) else $error("heap top shrank");
    // A result comes only from the response step.
    a_rsp_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_RESP) else $error("stray result");
    // No new request is taken while a result waits.
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready with result pending");
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for first_fit_heap_allocator: directed and random requests against a heap model.
module tb;
    localparam int HOLD_LIMIT = 20000;
    localparam int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS;
    localparam int HEADER_BYTES = ffha_pkg::HEADER_BYTES;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    ffha_pkg::req_t s_req = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    ffha_pkg::rsp_t m_rsp;
    logic          cfg_we = 1'b0;
    logic [16:0]   cfg_wdata = '0;

    always #5 aclk = ~aclk;

    first_fit_heap_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Heap shadow: block table linked in address order
    // ---------------------------------------------------------------
    logic [16:0] hp_limit;
    logic [15:0] hp_start [MAX_BLOCKS];
    logic [15:0] hp_bytes [MAX_BLOCKS];
    logic        hp_free  [MAX_BLOCKS];
    logic        hp_used  [MAX_BLOCKS];
    int          hp_next  [MAX_BLOCKS];
    int          hp_prev  [MAX_BLOCKS];
    int          hp_first;
    int          hp_last;
    logic [16:0] hp_top;

    ffha_pkg::rsp_t rsp_pending [$];
    int          fail_cnt = 0;
    bit          idle_on = 1'b1;  // random idling on both sides
    bit          hold_rx = 1'b0;  // receiver holds off completely
    int          quiet_cnt = 0;

    function automatic void heap_clear();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            hp_free[i] = 1'b0;
            hp_used[i] = 1'b0;
            hp_next[i] = MAX_BLOCKS;
            hp_prev[i] = MAX_BLOCKS;
            hp_start[i] = '0;
            hp_bytes[i] = '0;
        end
        hp_first = MAX_BLOCKS;
        hp_last = MAX_BLOCKS;
        hp_top = '0;
        hp_limit = 17'd65536;
    endfunction

    function automatic int spare_entry();
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (!hp_used[i])
                return i;
        return MAX_BLOCKS;
    endfunction

    // fold block s into its list predecessor d
    function automatic void merge_into(int d, int s);
        int n;
        n = hp_next[s];
        hp_next[d] = n;
        if (n < MAX_BLOCKS)
            hp_prev[n] = d;
        if (hp_last == s)
            hp_last = d;
        hp_bytes[d] = hp_bytes[d] + hp_bytes[s] + 16'(HEADER_BYTES);
        hp_used[s] = 1'b0;
        hp_free[s] = 1'b0;
    endfunction

    function automatic ffha_pkg::rsp_t heap_alloc(logic [15:0] size);
        ffha_pkg::rsp_t r;
        int b, steps, e, n;
        r = '0;
        r.status = ffha_pkg::ST_OK;
        if (size == 0) begin
            r.status = ffha_pkg::ST_ZERO_SIZE;
            return r;
        end
        b = hp_first;
        steps = 0;
        while (b < MAX_BLOCKS && steps < MAX_BLOCKS) begin
            if (hp_free[b] && hp_bytes[b] >= size)
                break;
            b = hp_next[b];
            steps++;
        end
        if (b < MAX_BLOCKS && steps < MAX_BLOCKS) begin
            if (32'(hp_bytes[b]) > 32'(size) + HEADER_BYTES) begin
                e = spare_entry();
                if (e < MAX_BLOCKS) begin
                    n = hp_next[b];
                    hp_used[e] = 1'b1;
                    hp_free[e] = 1'b1;
                    hp_start[e] = hp_start[b] + 16'(HEADER_BYTES) + size;
                    hp_bytes[e] = hp_bytes[b] - size - 16'(HEADER_BYTES);
                    hp_next[e] = n;
                    hp_prev[e] = b;
                    if (n < MAX_BLOCKS)
                        hp_prev[n] = e;
                    if (hp_last == b)
                        hp_last = e;
                    hp_next[b] = e;
                    hp_bytes[b] = size;
                end
            end
            hp_free[b] = 1'b0;
            r.result_address = hp_start[b] + 16'(HEADER_BYTES);
            return r;
        end
        // grow at the top; limit is capped by the address span
        if (32'(hp_top) + HEADER_BYTES + 32'(size)
                > ((hp_limit > 17'd65536) ? 32'd65536 : 32'(hp_limit))) begin
            r.status = ffha_pkg::ST_NO_SPACE;
            return r;
        end
        e = spare_entry();
        if (e >= MAX_BLOCKS) begin
            r.status = ffha_pkg::ST_NO_SPACE;
            return r;
        end
        hp_used[e] = 1'b1;
        hp_free[e] = 1'b0;
        hp_start[e] = hp_top[15:0];
        hp_bytes[e] = size;
        hp_next[e] = MAX_BLOCKS;
        hp_prev[e] = hp_last;
        if (hp_last < MAX_BLOCKS)
            hp_next[hp_last] = e;
        else
            hp_first = e;
        hp_last = e;
        hp_top = hp_top + 17'(HEADER_BYTES) + 17'(size);
        r.result_address = hp_start[e] + 16'(HEADER_BYTES);
        return r;
    endfunction

    function automatic ffha_pkg::rsp_t heap_release(logic [15:0] addr);
        ffha_pkg::rsp_t r;
        int b, n, p;
        r = '0;
        r.status = ffha_pkg::ST_OK;
        if (addr == 0)
            return r;
        b = MAX_BLOCKS;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (hp_used[i] && 32'(hp_start[i]) + HEADER_BYTES == 32'(addr)) begin
                b = i;
                break;
            end
        end
        if (b >= MAX_BLOCKS) begin
            r.status = ffha_pkg::ST_BAD_FREE;
            return r;
        end
        hp_free[b] = 1'b1;
        n = hp_next[b];
        if (n < MAX_BLOCKS && hp_free[n])
            merge_into(b, n);
        p = hp_prev[b];
        if (p < MAX_BLOCKS && hp_free[p])
            merge_into(p, b);
        return r;
    endfunction

    // pick a data address of a live block, or a random one if none
    function automatic logic [15:0] live_address();
        int picks [$];
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (hp_used[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return 16'($urandom);
        return hp_start[picks[$urandom_range(picks.size() - 1)]] + 16'(HEADER_BYTES);
    endfunction

    // ---------------------------------------------------------------
    // Request driver: valid held with a fixed payload until accepted
    // ---------------------------------------------------------------
    task automatic send_request(logic kind, logic [15:0] size, logic [15:0] addr);
        ffha_pkg::req_t rq;
        rq.req_type = kind;
        rq.req_size = size;
        rq.data_address = addr;
        // always move past the edge at which the previous request dropped valid
        do
            @(posedge aclk);
        while (idle_on && $urandom_range(99) < 37);
        s_req <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge; predict with state as of acceptance
        if (kind == ffha_pkg::REQ_ALLOC)
            rsp_pending.push_back(heap_alloc(size));
        else
            rsp_pending.push_back(heap_release(addr));
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (rsp_pending.size() != 0)
            @(posedge aclk);
        // a request may still be in flight; allow the full walk
        repeat (2 * MAX_BLOCKS + 20) @(posedge aclk);
    endtask

    task automatic write_limit(logic [16:0] value);
        drain_results();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge aclk);
        hp_limit = value;
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result check and receiver idling
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !hold_rx && !(idle_on && $urandom_range(99) < 37);
    end

    always @(posedge aclk) begin
        ffha_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_pending.size() == 0) begin
                $error("unexpected result status=%0d addr=%0h",
                       m_rsp.status, m_rsp.result_address);
                fail_cnt++;
            end else begin
                want = rsp_pending.pop_front();
                if (m_rsp.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, m_rsp.status);
                    fail_cnt++;
                end
                if (m_rsp.result_address !== want.result_address) begin
                    $error("result_address: expected %0h actual %0h",
                           want.result_address, m_rsp.result_address);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: stop if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt > HOLD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Zero size, null free, unknown address, double free, extremes
    task automatic test_directed();
        logic [15:0] a0, a1, a2;
        send_request(ffha_pkg::REQ_ALLOC, 16'd0, 16'hFFFF);
        send_request(ffha_pkg::REQ_FREE, 16'hFFFF, 16'd0);
        send_request(ffha_pkg::REQ_FREE, 16'd0, 16'd1234);
        send_request(ffha_pkg::REQ_ALLOC, 16'd1, 16'd0);
        a0 = 16'(HEADER_BYTES);
        send_request(ffha_pkg::REQ_ALLOC, 16'd100, 16'd0);
        a1 = live_address();
        send_request(ffha_pkg::REQ_ALLOC, 16'd200, 16'd0);
        send_request(ffha_pkg::REQ_FREE, 16'd0, a0 + 16'd33);  // second block data address (a0 + 33)
        send_request(ffha_pkg::REQ_FREE, 16'd0, 16'd65);       // same address again: double free
        send_request(ffha_pkg::REQ_FREE, 16'd0, 16'd65);       // same address a third time
        send_request(ffha_pkg::REQ_ALLOC, 16'd10, 16'd0);      // fits and splits the hole
        send_request(ffha_pkg::REQ_FREE, 16'd0, a0);
        send_request(ffha_pkg::REQ_ALLOC, 16'hFFFF, 16'd0);    // too large
        a2 = live_address();
        send_request(ffha_pkg::REQ_FREE, 16'hAAAA, a2);
        send_request(ffha_pkg::REQ_ALLOC, 16'd60000, 16'h5555);
        send_request(ffha_pkg::REQ_FREE, 16'd0, 16'hFFFF);
        send_request(ffha_pkg::REQ_ALLOC, 16'h8000, 16'd0);
    endtask

    // Limit register at its extremes and in between
    task automatic test_limit();
        write_limit(17'd0);
        send_request(ffha_pkg::REQ_ALLOC, 16'd1, 16'd0);
        write_limit(17'h1FFFF);
        send_request(ffha_pkg::REQ_ALLOC, 16'd16, 16'd0);
        write_limit(17'd40000);
        send_request(ffha_pkg::REQ_ALLOC, 16'd3000, 16'd0);
    endtask

    // Mostly allocate/free of live blocks, some noise; limits vary per phase
    task automatic random_phase(int count, bit big);
        logic [15:0] sz;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    sz = big ? 16'($urandom) : 16'($urandom_range(1, 400));
                    if ($urandom_range(19) == 0)
                        sz = 16'd0;
                    send_request(ffha_pkg::REQ_ALLOC, sz, 16'($urandom));
                end
                4, 5, 6, 7:
                    send_request(ffha_pkg::REQ_FREE, 16'($urandom), live_address());
                8:
                    send_request(ffha_pkg::REQ_FREE, 16'($urandom), 16'($urandom));
                default:
                    send_request(ffha_pkg::REQ_FREE, 16'($urandom), 16'd0);
            endcase
        end
    endtask

    // Receiver holds off while requests keep coming; sender then waits for all
    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (600) @(posedge aclk);
                hold_rx = 1'b0;
            end
            random_phase(12, 1'b0);
        join
        drain_results();
    endtask

    initial begin
        heap_clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_limit();
        write_limit(17'd20000);
        random_phase(150, 1'b0);
        idle_on = 1'b0;              // stretch with no idling
        random_phase(60, 1'b0);
        idle_on = 1'b1;
        test_backpressure();
        write_limit(17'd65536);
        random_phase(120, 1'b0);
        random_phase(20, 1'b1);
        write_limit(17'd1000);
        random_phase(60, 1'b0);

        drain_results();
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: first_fit_heap_allocator.f
hw/rtl/ffha_pkg.sv
hw/rtl/first_fit_heap_allocator.sv
bench/tb.sv
